// ===== design/sdsb_pkg.sv =====
// Package for the SHiP/DRRIP replacement engine: constants, types, command codes.
// No dependencies.
package sdsb_pkg;
  localparam int unsigned SetsDef     = 2048;
  localparam int unsigned WaysDef     = 16;
  localparam int unsigned LeadersDef  = 32;
  localparam int unsigned SelBitsDef  = 10;
  localparam int unsigned SigBitsDef  = 6;
  localparam int unsigned SetW        = 11;
  localparam int unsigned WayW        = 4;
  localparam int unsigned AddrW       = 64;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;
  localparam logic [15:0] DeltaLimRst = 16'd256;
  localparam logic [3:0]  NeededRst   = 4'd6;
  localparam logic [1:0]  RrpvMax     = 2'd3;
  localparam logic [7:0]  HistMask    = 8'hFF;
  localparam logic [4:0]  PhaseMask   = 5'h1F;
  localparam logic [3:0]  BypassMask  = 4'hF;

  typedef enum logic {
    CmdQuery  = 1'b0,
    CmdUpdate = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CfgDeltaLimit = 1'b0,
    CfgNeeded     = 1'b1
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic clr;      // clear pass step
    logic load;     // latch input word, issue reads
    logic exec;     // compute and write back
  } sdsb_cmd_t;

  typedef struct packed {
    logic clr_done;
  } sdsb_stat_t;
endpackage

// ===== design/sdsb_if.sv =====
// Valid/ready stream interfaces for the engine's channels.
// Depends on sdsb_pkg.
interface sdsb_in_if;
  import sdsb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [SetW-1:0]         set_index;
  logic [WayW-1:0]         way_index;
  logic [AddrW-1:0]        line_addr;
  logic [AddrW-1:0]        pc;
  logic                    hit;
  modport source (output valid, cmd, set_index, way_index, line_addr, pc, hit, input ready);
  modport sink   (input valid, cmd, set_index, way_index, line_addr, pc, hit, output ready);
endinterface

interface sdsb_out_if;
  import sdsb_pkg::*;
  logic            valid;
  logic            ready;
  logic [WayW-1:0] victim_way;
  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

interface sdsb_cfg_if;
  import sdsb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ship_drrip_stream_bypass_replacement.sv =====
// Top level of the SHiP/DRRIP replacement engine with stream bypass.
// A word is handled in two steps (memory read, then compute and write back);
// no new word is taken until the last is written back, as the per-set RRPV and
// stream memories have one read-modify-write port. A query result sits in an
// output register until taken; no new word is taken while it waits. After reset
// a clearing pass over the SETS rows (2048 by default; the signature table size
// if larger) initializes the memories; no word is taken meanwhile, config writes are.
module ship_drrip_stream_bypass_replacement #(
  parameter int unsigned SETS           = sdsb_pkg::SetsDef,
  parameter int unsigned WAYS           = sdsb_pkg::WaysDef,
  parameter int unsigned LEADER_SETS    = sdsb_pkg::LeadersDef,
  parameter int unsigned SELECTOR_BITS  = sdsb_pkg::SelBitsDef,
  parameter int unsigned SIGNATURE_BITS = sdsb_pkg::SigBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sdsb_in_if.sink     in_if,
  sdsb_out_if.source  out_if,
  sdsb_cfg_if.sink    cfg_if
);
  import sdsb_pkg::*;

  sdsb_cmd_t   cmd;
  sdsb_stat_t  stat;
  logic [15:0] delta_limit_q;
  logic [3:0]  needed_q;

  // configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_limit_q <= DeltaLimRst;
      needed_q      <= NeededRst;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CfgDeltaLimit: delta_limit_q <= cfg_if.data;
        CfgNeeded:     needed_q      <= cfg_if.data[3:0];
        default: ;
      endcase
    end
  end

  sdsb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_query_i  (in_if.cmd == CmdQuery),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdsb_dpath #(
    .SETS(SETS), .WAYS(WAYS), .LEADER_SETS(LEADER_SETS),
    .SELECTOR_BITS(SELECTOR_BITS), .SIGNATURE_BITS(SIGNATURE_BITS)
  ) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_cmd_i      (in_if.cmd),
    .in_set_i      (in_if.set_index),
    .in_way_i      (in_if.way_index),
    .in_addr_i     (in_if.line_addr),
    .in_pc_i       (in_if.pc),
    .in_hit_i      (in_if.hit),
    .delta_limit_i (delta_limit_q),
    .needed_i      (needed_q),
    .out_take_i    (out_if.valid && out_if.ready),
    .victim_way_o  (out_if.victim_way)
  );
endmodule

// ===== design/sdsb_ctrl.sv =====
// Controller FSM: clearing pass, then load/execute per word, output handoff.
// Depends on sdsb_pkg.
module sdsb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_query_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sdsb_pkg::sdsb_stat_t stat_i,
  output sdsb_pkg::sdsb_cmd_t  cmd_o
);
  import sdsb_pkg::*;

  typedef enum logic [2:0] {
    StClear = 3'b001,
    StIdle  = 3'b010,
    StExec  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_query_q;
  logic   accept;

  // a new word is taken in idle once the output slot is free
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        cmd_o.load = accept;
        if (accept) state_d = StExec;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StIdle;
        if (is_query_q) out_valid_d = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
      is_query_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) is_query_q <= in_query_i;
    end
  end

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !in_ready_o) else $error("accept during clear");
  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StExec)) else $error("load not followed by exec");
  a_query_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec && is_query_q) |=> out_valid_q) else $error("query lost");
endmodule

// ===== design/sdsb_dpath.sv =====
// Datapath: per-set RRPV row, stream detector and signature memories, selector.
// Depends on sdsb_pkg.
module sdsb_dpath #(
  parameter int unsigned SETS           = sdsb_pkg::SetsDef,
  parameter int unsigned WAYS           = sdsb_pkg::WaysDef,
  parameter int unsigned LEADER_SETS    = sdsb_pkg::LeadersDef,
  parameter int unsigned SELECTOR_BITS  = sdsb_pkg::SelBitsDef,
  parameter int unsigned SIGNATURE_BITS = sdsb_pkg::SigBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sdsb_pkg::sdsb_cmd_t          cmd_i,
  output sdsb_pkg::sdsb_stat_t         stat_o,
  input  logic                         in_cmd_i,
  input  logic [sdsb_pkg::SetW-1:0]    in_set_i,
  input  logic [sdsb_pkg::WayW-1:0]    in_way_i,
  input  logic [sdsb_pkg::AddrW-1:0]   in_addr_i,
  input  logic [sdsb_pkg::AddrW-1:0]   in_pc_i,
  input  logic                         in_hit_i,
  input  logic [15:0]                  delta_limit_i,
  input  logic [3:0]                   needed_i,
  input  logic                         out_take_i,
  output logic [sdsb_pkg::WayW-1:0]    victim_way_o
);
  import sdsb_pkg::*;

  localparam int unsigned SetIdxW  = $clog2(SETS);
  localparam int unsigned WayIdxW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SigN     = 1 << SIGNATURE_BITS;
  localparam int unsigned SpacingR = SETS / LEADER_SETS;
  localparam int unsigned Spacing  = (SpacingR == 0) ? 1 : SpacingR;
  localparam int unsigned SpcW     = (Spacing > 1) ? $clog2(Spacing) : 1;
  localparam logic [SELECTOR_BITS-1:0] SelMid = 1 << (SELECTOR_BITS - 1);
  localparam logic [SELECTOR_BITS-1:0] SelMax = '1;
  localparam int unsigned StW      = AddrW + 8 + 2;
  // clearing pass covers the larger of the set memories and the signature table
  localparam int unsigned ClrN     = (SigN > SETS) ? SigN : SETS;
  localparam int unsigned ClrW     = $clog2(ClrN);

  // memories: one row per set, one counter per signature
  logic [2*WAYS-1:0] rrpv_mem [SETS];
  logic [StW-1:0]    strm_mem [SETS];
  logic [1:0]        sig_mem  [SigN];

  logic [SELECTOR_BITS-1:0] sel_q;
  logic [4:0]               phase_q;
  logic [ClrW:0]            clr_cnt_q;
  logic                     clr_busy;

  logic [2*WAYS-1:0]   row_q;
  logic [StW-1:0]      st_q;
  logic [1:0]          ctr_q;
  logic [SetIdxW-1:0]  set_q;
  logic [WayIdxW-1:0]  way_q;
  logic [AddrW-1:0]    addr_q;
  logic [SIGNATURE_BITS-1:0] sig_idx_q;
  logic                hit_q, upd_q;
  logic [WayW-1:0]     victim_q;

  logic [SetIdxW-1:0]  set_in;
  logic [SIGNATURE_BITS-1:0] sig_in;
  assign set_in = SetIdxW'(in_set_i);
  assign sig_in = in_pc_i[SIGNATURE_BITS-1:0] ^ in_pc_i[2*SIGNATURE_BITS-1:SIGNATURE_BITS];

  assign clr_busy        = cmd_i.clr && !clr_cnt_q[ClrW];
  assign stat_o.clr_done = clr_cnt_q[ClrW];
  assign victim_way_o    = victim_q;

  // ---- victim search over the registered row
  logic [1:0]         maxv;
  logic [WayIdxW-1:0] best;
  logic [1:0]         age;
  logic [2*WAYS-1:0]  aged_row;
  always_comb begin
    maxv = '0;
    best = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row_q[2*w +: 2] > maxv) begin
        maxv = row_q[2*w +: 2];
        best = WayIdxW'(w);
      end
    end
    age = RrpvMax - maxv;
    for (int w = 0; w < WAYS; w++) aged_row[2*w +: 2] = row_q[2*w +: 2] + age;
  end

  // ---- stream detector
  logic [AddrW-1:0] last, delta;
  logic [7:0]       hist, hist_n;
  logic [1:0]       lvl, lvl_n;
  logic             mono;
  logic [3:0]       ones;
  always_comb begin
    last  = st_q[StW-1 -: AddrW];
    hist  = st_q[9:2];
    lvl   = st_q[1:0];
    delta = (last == '0) ? '0 : ((addr_q > last) ? addr_q - last : last - addr_q);
    mono  = (delta != '0) && (delta < {48'd0, delta_limit_i});
    hist_n = {hist[6:0], mono} & HistMask;
    ones  = '0;
    for (int i = 0; i < 8; i++) ones = ones + {3'd0, hist_n[i]};
    if (ones >= needed_i) lvl_n = (lvl == RrpvMax) ? lvl : lvl + 2'd1;
    else                  lvl_n = (lvl == 2'd0) ? lvl : lvl - 2'd1;
  end

  // ---- insertion choice
  logic [4:0]  phase_n;
  logic        leader, srrip_ld, use_brrip, bypass;
  logic [1:0]  ctr, ins;
  logic [SetIdxW-1:0] lnum;
  always_comb begin
    phase_n  = (phase_q + 5'd1) & PhaseMask;
    leader   = (SpacingR <= 1) ? 1'b1 : (set_q[SpcW-1:0] == '0);
    lnum     = set_q / SetIdxW'(Spacing);
    srrip_ld = {1'b0, lnum} < (SetIdxW + 1)'(LEADER_SETS / 2);
    use_brrip = leader ? !srrip_ld : (sel_q < SelMid);
    bypass   = (lvl_n >= 2'd2) && ((phase_n[3:0] & BypassMask) == 4'd0);
    ctr      = ctr_q;
    if (bypass)          ins = RrpvMax;
    else if (ctr >= 2'd2) ins = 2'd0;
    else if (ctr == 2'd0) ins = RrpvMax;
    else if (use_brrip)  ins = (phase_n == 5'd0) ? 2'd0 : RrpvMax;
    else                 ins = 2'd2;
  end

  // memory ports: reads on load, writes on exec or clear
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      if (clr_cnt_q < (ClrW + 1)'(SETS)) begin
        rrpv_mem[clr_cnt_q[SetIdxW-1:0]] <= '1;
        strm_mem[clr_cnt_q[SetIdxW-1:0]] <= '0;
      end
      if (clr_cnt_q < (ClrW + 1)'(SigN)) sig_mem[clr_cnt_q[SIGNATURE_BITS-1:0]] <= 2'd1;
    end else if (cmd_i.exec) begin
      if (!upd_q) begin
        rrpv_mem[set_q] <= aged_row;
      end else begin
        logic [2*WAYS-1:0] r;
        r = row_q;
        r[2*way_q +: 2] = hit_q ? 2'd0 : ins;
        rrpv_mem[set_q] <= r;
        strm_mem[set_q] <= {addr_q, hist_n, lvl_n};
        // signature counter: up on a hit, down on a miss that is not bypassed
        if (hit_q) begin
          if (ctr != RrpvMax) sig_mem[sig_idx_q] <= ctr + 2'd1;
        end else if (!bypass && ctr != 2'd0) begin
          sig_mem[sig_idx_q] <= ctr - 2'd1;
        end
      end
    end
    if (cmd_i.load) begin
      row_q <= rrpv_mem[set_in];
      st_q  <= strm_mem[set_in];
      ctr_q <= sig_mem[sig_in];
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q     <= set_in;
      way_q     <= WayIdxW'(in_way_i % WAYS);
      addr_q    <= in_addr_i;
      sig_idx_q <= sig_in;
      hit_q     <= in_hit_i;
      upd_q     <= (in_cmd_i == CmdUpdate);
    end
    if (cmd_i.exec && !upd_q) victim_q <= WayW'(best);
  end

  // control state: selector, phase, clear count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q     <= SelMid;
      phase_q   <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (clr_busy) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.exec && upd_q) begin
        phase_q <= phase_n;
        if (!hit_q && leader) begin
          if (srrip_ld) begin
            if (sel_q != SelMax) sel_q <= sel_q + 1'b1;
          end else if (sel_q != '0) begin
            sel_q <= sel_q - 1'b1;
          end
        end
      end
    end
  end

  a_clr_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.clr_done |=> stat_o.clr_done) else $error("clear pass restarted");
  a_no_load_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> stat_o.clr_done) else $error("load before clear done");
  a_victim_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec && !out_take_i |=> $stable(victim_q)) else $error("victim changed");
endmodule
